FILE: design/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg: shared definitions for the matrix multiplier
// Command codes, register indexes, sequencer states and the control struct
// that the sequencer sends to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM = 8;

    localparam int DATA_W = 32;
    localparam int DIM_W  = 4;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic acc_clr;
        logic rd_issue;
        logic load_out;
        logic zero_out;
    } mac_ctrl_t;

    // A zero dimension counts as one, anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxd);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = 4'd1;
        end
        else if (v > maxd)
        begin
            r = maxd;
        end
        return r;
    endfunction

endpackage

FILE: design/mm_mem.sv
// ----------------------------------------------------------------------------
// mm_mem: element store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mm_mem #(
    parameter int DEPTH = mm_pkg::MAX_DIM * mm_pkg::MAX_DIM,
    parameter int AW    = 6
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [mm_pkg::DATA_W-1:0]   wdata,
    input  logic [AW-1:0]               raddr,
    output logic [mm_pkg::DATA_W-1:0]   rdata
);

    logic [mm_pkg::DATA_W-1:0] mem [DEPTH];
    logic [mm_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mm_mac.sv
// ----------------------------------------------------------------------------
// mm_mac: shared multiply-accumulate unit
// Registered 32x32 signed multiply, exact wide accumulation, then rounding
// to Q16.16 with halves toward plus infinity and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mm_mac #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mm_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [mm_pkg::DATA_W-1:0]   a_data,
    input  logic signed [mm_pkg::DATA_W-1:0]   b_data,
    output logic                               busy,
    output logic signed [mm_pkg::DATA_W-1:0]   product
);

    localparam int PROD_W = 2 * mm_pkg::DATA_W;
    localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_DIM);
    localparam int SH_W   = ACC_W - 16;

    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(64'sd2147483647);
    localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-64'sd2147483648);

    logic                              rd_vld_reg;
    logic                              mul_vld_reg;
    logic signed [PROD_W-1:0]          mul_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;
    logic signed [mm_pkg::DATA_W-1:0]  product_reg;
    logic signed [mm_pkg::DATA_W-1:0]  product_next;
    logic signed [ACC_W-1:0]           rounded;
    logic signed [SH_W-1:0]            shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= ctrl.rd_issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg     <= a_data * b_data;
        acc_reg     <= acc_next;
        product_reg <= product_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (mul_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(mul_reg);
        end
    end

    // Adding one half before the floor shift rounds halves upward.
    always_comb
    begin
        rounded      = acc_reg + ACC_W'(32'sh8000);
        shifted      = rounded[ACC_W-1:16];
        product_next = product_reg;
        if (ctrl.zero_out)
        begin
            product_next = '0;
        end
        else if (ctrl.load_out)
        begin
            if (shifted > SAT_MAX)
            begin
                product_next = 32'sh7fffffff;
            end
            else if (shifted < SAT_MIN)
            begin
                product_next = 32'sh80000000;
            end
            else
            begin
                product_next = shifted[mm_pkg::DATA_W-1:0];
            end
        end
    end

    assign busy    = rd_vld_reg | mul_vld_reg;
    assign product = product_reg;

endmodule

FILE: design/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl: multiply sequencer
// Walks the row, column and inner indexes, issues store reads to the shared
// multiply-accumulate unit and hands each finished element to the output.
// ----------------------------------------------------------------------------
module mm_ctrl #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM,
    parameter int AW      = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mm_pkg::DIM_W-1:0]   a_rows,
    input  logic [mm_pkg::DIM_W-1:0]   a_cols,
    input  logic [mm_pkg::DIM_W-1:0]   b_rows,
    input  logic [mm_pkg::DIM_W-1:0]   b_cols,
    input  logic                       out_ready,
    input  logic                       busy,
    output logic                       in_ready,
    output logic                       out_valid,
    output logic [AW-1:0]              a_raddr,
    output logic [AW-1:0]              b_raddr,
    output mm_pkg::mac_ctrl_t          mac_ctrl,
    output logic [2:0]                 out_row,
    output logic [2:0]                 out_col,
    output logic                       dim_error,
    output logic                       last
);

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [mm_pkg::DIM_W-1:0] MAXD = mm_pkg::DIM_W'(MAX_DIM);

    mm_pkg::state_t state_reg;
    mm_pkg::state_t state_next;

    logic [CW-1:0] i_reg;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_next;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] k_next;
    logic          err_reg;
    logic          err_next;

    logic [mm_pkg::DIM_W-1:0] ar;
    logic [mm_pkg::DIM_W-1:0] ac;
    logic [mm_pkg::DIM_W-1:0] br;
    logic [mm_pkg::DIM_W-1:0] bc;
    logic                     k_end;
    logic                     j_end;
    logic                     i_end;
    logic [7:0]               a_lin;
    logic [7:0]               b_lin;

    assign ar = mm_pkg::clamp_dim(a_rows, MAXD);
    assign ac = mm_pkg::clamp_dim(a_cols, MAXD);
    assign br = mm_pkg::clamp_dim(b_rows, MAXD);
    assign bc = mm_pkg::clamp_dim(b_cols, MAXD);

    assign k_end = (mm_pkg::DIM_W'(k_reg) == ac - 4'd1);
    assign j_end = (mm_pkg::DIM_W'(j_reg) == bc - 4'd1);
    assign i_end = (mm_pkg::DIM_W'(i_reg) == ar - 4'd1);

    assign a_lin = 8'(i_reg) * 8'(ac) + 8'(k_reg);
    assign b_lin = 8'(k_reg) * 8'(bc) + 8'(j_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (ac != br) ? mm_pkg::ST_OUT : mm_pkg::ST_ISSUE;
                end
            end
            mm_pkg::ST_ISSUE:
            begin
                if (k_end)
                begin
                    state_next = mm_pkg::ST_DRAIN;
                end
            end
            mm_pkg::ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = mm_pkg::ST_OUT;
                end
            end
            mm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (i_end && j_end)
                    begin
                        state_next = mm_pkg::ST_IDLE;
                    end
                    else if (!err_reg)
                    begin
                        state_next = mm_pkg::ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = mm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        err_next = err_reg;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    i_next   = '0;
                    j_next   = '0;
                    k_next   = '0;
                    err_next = (ac != br);
                end
            end
            mm_pkg::ST_ISSUE:
            begin
                k_next = k_end ? '0 : k_reg + 1'b1;
            end
            mm_pkg::ST_OUT:
            begin
                if (out_ready && !(i_end && j_end))
                begin
                    if (j_end)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        in_ready          = 1'b0;
        out_valid         = 1'b0;
        mac_ctrl.acc_clr  = 1'b0;
        mac_ctrl.rd_issue = 1'b0;
        mac_ctrl.load_out = 1'b0;
        mac_ctrl.zero_out = 1'b0;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                in_ready          = 1'b1;
                mac_ctrl.acc_clr  = start;
                mac_ctrl.zero_out = start && (ac != br);
            end
            mm_pkg::ST_ISSUE:
            begin
                mac_ctrl.rd_issue = 1'b1;
            end
            mm_pkg::ST_DRAIN:
            begin
                mac_ctrl.load_out = !busy;
            end
            mm_pkg::ST_OUT:
            begin
                out_valid        = 1'b1;
                mac_ctrl.acc_clr = out_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign a_raddr   = a_lin[AW-1:0];
    assign b_raddr   = b_lin[AW-1:0];
    assign out_row   = 3'(i_reg);
    assign out_col   = 3'(j_reg);
    assign dim_error = err_reg;
    assign last      = i_end && j_end;

endmodule

FILE: design/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply: fixed-point dense matrix multiply, C = A x B
// Load items fill the A and B stores; a start item emits every element of C.
// ----------------------------------------------------------------------------
// A load item is written to its store and the block is ready again at once.
// A start item emits C in row-major order: per element, one store read and
// multiply per inner term, a pipeline drain, then rounding and output. A
// dimension error gives one zero per cycle while the output is ready. The
// input is not ready from the start transfer until the last result. Reset
// sets all dimension registers to 8 and idles; the stores stay undefined.
// ----------------------------------------------------------------------------
module matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,

    // Command channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         cmd,
    input  logic [5:0]                         elem_index,
    input  logic signed [31:0]                 elem_value,

    // Result channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 product,
    output logic [2:0]                         out_row,
    output logic [2:0]                         out_col,
    output logic                               dim_error,
    output logic                               last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [mm_pkg::DIM_W-1:0] a_rows_reg;
    logic [mm_pkg::DIM_W-1:0] a_cols_reg;
    logic [mm_pkg::DIM_W-1:0] b_rows_reg;
    logic [mm_pkg::DIM_W-1:0] b_cols_reg;

    logic                     cfg_wr;
    logic                     in_xfer;
    logic                     idx_ok;
    logic                     a_we;
    logic                     b_we;
    logic                     start;
    logic [AW-1:0]            a_raddr;
    logic [AW-1:0]            b_raddr;
    logic [31:0]              a_rdata;
    logic [31:0]              b_rdata;
    logic                     mac_busy;
    mm_pkg::mac_ctrl_t        mac_ctrl;

    // ------------------------------------------------------------------
    // Configuration registers. The register index is taken from the word
    // address; the byte offset bits are not decoded. The port never waits.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= mm_pkg::DIM_RESET;
            a_cols_reg <= mm_pkg::DIM_RESET;
            b_rows_reg <= mm_pkg::DIM_RESET;
            b_cols_reg <= mm_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                mm_pkg::REG_A_ROWS: a_rows_reg <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_A_COLS: a_cols_reg <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_B_ROWS: b_rows_reg <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_B_COLS: b_cols_reg <= pwdata[mm_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mm_pkg::REG_A_ROWS: prdata = 32'(a_rows_reg);
            mm_pkg::REG_A_COLS: prdata = 32'(a_cols_reg);
            mm_pkg::REG_B_ROWS: prdata = 32'(b_rows_reg);
            mm_pkg::REG_B_COLS: prdata = 32'(b_cols_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Command decode. Loads beyond the store depth are dropped, and the
    // unused command code is taken and ignored.
    // ------------------------------------------------------------------
    assign in_xfer = in_valid && in_ready;
    assign idx_ok  = (7'(elem_index) < 7'(DEPTH));
    assign a_we    = in_xfer && (cmd == mm_pkg::CMD_LOAD_A) && idx_ok;
    assign b_we    = in_xfer && (cmd == mm_pkg::CMD_LOAD_B) && idx_ok;
    assign start   = in_xfer && (cmd == mm_pkg::CMD_START);

    // ------------------------------------------------------------------
    // Element stores. Writes come only from load transfers while idle, and
    // reads only from the sequencer while it runs, so the ports never clash.
    // ------------------------------------------------------------------
    mm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (elem_index[AW-1:0]),
        .wdata (elem_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (elem_index[AW-1:0]),
        .wdata (elem_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: steps the inner index once per cycle for each element,
    // waits for the multiply-accumulate pipeline to empty, then presents
    // the element and holds it until the result transfer.
    // ------------------------------------------------------------------
    mm_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .a_rows    (a_rows_reg),
        .a_cols    (a_cols_reg),
        .b_rows    (b_rows_reg),
        .b_cols    (b_cols_reg),
        .out_ready (out_ready),
        .busy      (mac_busy),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .mac_ctrl  (mac_ctrl),
        .out_row   (out_row),
        .out_col   (out_col),
        .dim_error (dim_error),
        .last      (last)
    );

    // ------------------------------------------------------------------
    // Shared multiply-accumulate unit. The sum of exact products is kept
    // at full width and rounded once when the element is finished.
    // ------------------------------------------------------------------
    mm_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .busy    (mac_busy),
        .product (product)
    );

endmodule
